// File: design/ksd_pkg.sv
`timescale 1ns / 1ps

package ksd_pkg;

  localparam int NUM_COLUMNS = 4;
  localparam int NUM_ROWS    = 4;

  localparam int COL_W     = $clog2(NUM_COLUMNS);
  localparam int ROW_PINS  = 4;
  localparam int ROWS_SEEN = (NUM_ROWS < ROW_PINS) ? NUM_ROWS : ROW_PINS;
  localparam logic [ROW_PINS-1:0] ROW_MASK = ROW_PINS'((1 << ROWS_SEEN) - 1);

  localparam int CODE_W  = 8;
  localparam int CNT_W   = 8;
  localparam int TABLE_W = 64;
  localparam int DRIVE_W = 4;

  // configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE_AMOUNT = 2'd0;
  localparam logic [1:0] CFG_KEY_TABLE_LOW   = 2'd1;
  localparam logic [1:0] CFG_KEY_TABLE_HIGH  = 2'd2;

  typedef enum logic [1:0] {
    PH_DRIVE  = 2'd0,
    PH_SAMPLE = 2'd1,
    PH_REPORT = 2'd2
  } scan_phase_e;

  typedef enum logic [2:0] {
    DB_INIT       = 3'd0,
    DB_STABLE_OFF = 3'd1,
    DB_COUNT_ON   = 3'd2,
    DB_STABLE_ON  = 3'd3,
    DB_COUNT_OFF  = 3'd4
  } db_state_e;

endpackage

// File: design/ksd_if.sv
`timescale 1ns / 1ps

interface ksd_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] row_lines;

  modport source (output valid, output row_lines, input ready);
  modport sink   (input valid, input row_lines, output ready);
endinterface

interface ksd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] column_drive;
  logic [1:0] scan_phase_out;
  logic       press_event;
  logic       key_valid;
  logic [7:0] key_code;

  modport source (output valid, output column_drive, output scan_phase_out,
                  output press_event, output key_valid, output key_code, input ready);
  modport sink   (input valid, input column_drive, input scan_phase_out,
                  input press_event, input key_valid, input key_code, output ready);
endinterface

// File: design/keypad_scan_debounce.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                                            Handshake
// in_i      in   row_lines[3:0]                                     valid/ready
// out_o     out  column_drive, scan_phase_out, press_event,         valid/ready
//                key_valid, key_code[7:0]
// cfg       in   cfg_idx_i[1:0], cfg_data_i[63:0]                   cfg_we_i
//
// One scan tick per clock: an accepted item updates the scan state and loads
// the result register in the same cycle, so the result appears in the cycle after.
// The single result register sets the rate; a new tick is taken whenever that
// register is empty or is being drained in the same cycle.
// Reset (rst_ni low, async) puts the scan at the drive phase, last column,
// every debouncer in its init state, configuration registers cleared.
// A stalled output holds the result and blocks new ticks until it is taken.

module keypad_scan_debounce
  import ksd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  ksd_in_if.sink                  in_i,
  ksd_out_if.source               out_o,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [TABLE_W-1:0]      cfg_data_i
);

  // configuration
  logic [CNT_W-1:0]   debounce_amount_q;
  logic [TABLE_W-1:0] table_low_q, table_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_amount_q <= '0;
      table_low_q       <= '0;
      table_high_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE_AMOUNT: debounce_amount_q <= cfg_data_i[CNT_W-1:0];
        CFG_KEY_TABLE_LOW:   table_low_q       <= cfg_data_i;
        CFG_KEY_TABLE_HIGH:  table_high_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // scan state
  scan_phase_e             phase_q, phase_d;
  logic [COL_W-1:0]        col_q, col_d;
  logic [ROW_PINS-1:0]     rows_q, rows_d;
  logic                    edge_q, edge_d;
  db_state_e               db_state_q [NUM_COLUMNS];
  logic [CNT_W-1:0]        db_cnt_q   [NUM_COLUMNS];
  db_state_e               db_state_d;
  logic [CNT_W-1:0]        db_cnt_d;
  logic                    db_edge;

  // result register
  logic                    out_valid_q;
  logic [DRIVE_W-1:0]      drive_q, drive_d;
  logic [1:0]              phase_out_q, phase_out_d;
  logic                    press_q, press_d;
  logic                    kvalid_q, kvalid_d;
  logic [CODE_W-1:0]       code_q, code_d;

  logic                    in_fire;
  logic                    any_low;
  logic [ROW_PINS-1:0]     low_rows;
  logic                    one_low;
  logic [1:0]              row_idx;
  logic [2:0]              col3;
  logic [TABLE_W-1:0]      tbl_sel;
  logic [2:0]              byte_idx;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  assign rows_d  = (in_i.row_lines | ~ROW_MASK);
  assign any_low = (rows_d != {ROW_PINS{1'b1}});

  // debouncer of the current column, stepped in the sample phase
  always_comb begin
    db_state_d = db_state_q[col_q];
    db_cnt_d   = db_cnt_q[col_q];
    db_edge    = 1'b0;
    case (db_state_q[col_q])
      DB_INIT: begin
        db_state_d = DB_STABLE_OFF;
        db_cnt_d   = '0;
      end
      DB_STABLE_OFF: begin
        if (any_low) begin
          db_state_d = DB_COUNT_ON;
          db_edge    = 1'b1;
        end
      end
      DB_COUNT_ON: begin
        if (db_cnt_q[col_q] < debounce_amount_q) begin
          db_cnt_d = db_cnt_q[col_q] + 1'b1;
        end else begin
          db_state_d = DB_STABLE_ON;
          db_cnt_d   = '0;
        end
      end
      DB_STABLE_ON: begin
        if (!any_low) db_state_d = DB_COUNT_OFF;
      end
      DB_COUNT_OFF: begin
        if (db_cnt_q[col_q] < debounce_amount_q) begin
          db_cnt_d = db_cnt_q[col_q] + 1'b1;
        end else begin
          db_state_d = DB_STABLE_OFF;
          db_cnt_d   = '0;
        end
      end
      default: db_state_d = DB_INIT;
    endcase
  end

  // key decode from the rows latched in the sample phase
  assign low_rows = ~rows_q;
  assign one_low  = (low_rows != '0) && ((low_rows & (low_rows - 1'b1)) == '0);
  assign col3     = 3'(col_q);

  always_comb begin
    case (low_rows)
      4'b0010: row_idx = 2'd1;
      4'b0100: row_idx = 2'd2;
      4'b1000: row_idx = 2'd3;
      default: row_idx = 2'd0;
    endcase
  end

  assign tbl_sel  = row_idx[1] ? table_high_q : table_low_q;
  assign byte_idx = {row_idx[0], col3[1:0]};

  always_comb begin
    phase_d     = phase_q;
    col_d       = col_q;
    edge_d      = edge_q;
    press_d     = 1'b0;
    kvalid_d    = 1'b0;
    code_d      = '0;
    phase_out_d = PH_REPORT;
    case (phase_q)
      PH_DRIVE: begin
        phase_out_d = PH_DRIVE;
        col_d       = (int'(col_q) == NUM_COLUMNS - 1) ? '0 : col_q + 1'b1;
        phase_d     = PH_SAMPLE;
      end
      PH_SAMPLE: begin
        phase_out_d = PH_SAMPLE;
        edge_d      = db_edge;
        phase_d     = PH_REPORT;
      end
      PH_REPORT: begin
        if (edge_q) begin
          press_d = 1'b1;
          if (one_low) begin
            kvalid_d = 1'b1;
            if (col3 < 3'd4) code_d = tbl_sel[{byte_idx, 3'b000} +: CODE_W];
          end
        end
        phase_d = PH_DRIVE;
      end
      default: phase_d = PH_DRIVE;  // unused code: report-like, no press
    endcase
    // the drive tick already shows the newly selected column
    drive_d = (3'(col_d) < 3'd4) ? ~(DRIVE_W'(1) << col_d) : {DRIVE_W{1'b1}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DRIVE;
      col_q   <= COL_W'(NUM_COLUMNS - 1);
      rows_q  <= {ROW_PINS{1'b1}};
      edge_q  <= 1'b0;
      for (int i = 0; i < NUM_COLUMNS; i++) begin
        db_state_q[i] <= DB_INIT;
        db_cnt_q[i]   <= '0;
      end
    end else if (in_fire) begin
      phase_q <= phase_d;
      col_q   <= col_d;
      edge_q  <= edge_d;
      if (phase_q == PH_SAMPLE) begin
        rows_q            <= rows_d;
        db_state_q[col_q] <= db_state_d;
        db_cnt_q[col_q]   <= db_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      drive_q     <= drive_d;
      phase_out_q <= phase_out_d;
      press_q     <= press_d;
      kvalid_q    <= kvalid_d;
      code_q      <= code_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.column_drive   = drive_q;
  assign out_o.scan_phase_out = phase_out_q;
  assign out_o.press_event    = press_q;
  assign out_o.key_valid      = kvalid_q;
  assign out_o.key_code       = code_q;

  // press only ever reported in the report phase
  a_press_in_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && press_q |-> phase_out_q == PH_REPORT)
    else $error("press reported outside report phase");

  // a valid key or a nonzero code needs a press
  a_key_needs_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kvalid_q || code_q != '0) |-> press_q)
    else $error("key data without press");

  // at most one column driven low
  a_one_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $countones(drive_q) >= DRIVE_W - 1)
    else $error("more than one column driven low");

  // a drive tick is always followed by a sample tick
  a_drive_then_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q == PH_DRIVE |=> phase_q == PH_SAMPLE)
    else $error("scan phase skipped sample");

  // edge flag only raised by a sample tick
  a_edge_from_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(edge_q) |-> $past(phase_q) == PH_SAMPLE && $past(in_fire))
    else $error("edge flag set outside sample phase");

endmodule
